// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the Zobrist key accumulator.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- src/zka_pkg.sv -----
// Types and constants of the Zobrist key accumulator.
// No dependencies; used by zka_ctrl, zka_datapath and the top level.
package zka_pkg;

    // Item kinds
    localparam logic [1:0] MODE_PIECE = 2'd0;
    localparam logic [1:0] MODE_EP    = 2'd1;
    localparam logic [1:0] MODE_TURN  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Row layout of the generation order
    localparam int PIECE_KINDS = 7;
    localparam int EP_ROW_BASE = 35;
    localparam int TURN_ROW    = 40;
    localparam int ROW_W       = 6;
    localparam int ORD_OFFSET  = 2;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam int          SHIFT_A      = 30;
    localparam int          SHIFT_B      = 27;
    localparam int          SHIFT_OUT    = 31;

    // Partial product being formed by the shared 32x32 multiplier
    typedef enum logic [1:0] {
        PH_LL = 2'd0,   // lo * lo, full 64 bits
        PH_HL = 2'd1,   // hi * lo, low 32 bits into upper word
        PH_LH = 2'd2    // lo * hi, low 32 bits into upper word, write back
    } t_mphase;

    // Which constant multiplies the working word
    typedef enum logic [1:0] {
        MC_GAMMA = 2'd0,
        MC_A     = 2'd1,
        MC_B     = 2'd2
    } t_mconst;

    // Xor-shift amount ahead of the second and third multiply
    typedef enum logic {
        XS_A = 1'b0,
        XS_B = 1'b1
    } t_xshift;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mphase phase;
        t_mconst csel;
        logic    xs_en;
        t_xshift xsel;
        logic    fold;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

// ----- src/zobrist_key_accumulator.sv -----
// Zobrist key accumulator. Each request (piece placement, en-passant square or
// side to move) has its splitmix64 word regenerated from its ordinal in the table
// generation order and XORed into a 64-bit key; the request flagged last sends the
// key out and clears the accumulator. One request at a time is taken; the input stalls
// until it is done, and longer when it sends a key while a previous key waits. The pace
// is set by the single shared 32x32 multiplier: each of the three 64-bit constant
// multiplies is formed from three partial products, one per cycle, with two xor-shift
// steps between them, a fold step and, on last, an emit step. The key sits in an output
// register, so a waiting result does not block a new request until its emit step.
// Mode code 3 adds no word but its last flag is honored.
// Depends on zka_pkg, zka_ctrl, zka_datapath and assert_macros.svh.
`include "assert_macros.svh"

module zobrist_key_accumulator #(
    parameter int BOARD_SQUARES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_color,
    input  logic [2:0]  i_piece,
    input  logic [7:0]  i_square,
    input  logic        i_last,
    // key channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_key
);
    import zka_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequence one request at a time
    zka_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Ordinal, multiply chain, accumulator and output key register
    zka_datapath #(
        .BOARD_SQUARES (BOARD_SQUARES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_mode   (i_mode),
        .i_color  (i_color),
        .i_piece  (i_piece),
        .i_square (i_square),
        .i_last   (i_last),
        .o_sts    (w_sts),
        .o_key    (o_key)
    );

    // An accepted request keeps the input side busy in the next cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // Emit never overwrites a key that is still waiting
    `ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, w_cmd.emit, !o_valid || !i_stall)
    // Emit always presents a key in the next cycle
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_cmd.emit, o_valid)

endmodule

// ----- src/zka_datapath.sv -----
// Datapath of the Zobrist key accumulator: ordinal, shared multiplier, accumulator.
// Depends on zka_pkg; driven by commands from zka_ctrl.
module zka_datapath #(
    parameter int BOARD_SQUARES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  zka_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]       i_mode,
    input  logic [2:0]       i_color,
    input  logic [2:0]       i_piece,
    input  logic [7:0]       i_square,
    input  logic             i_last,
    output zka_pkg::t_dp_sts o_sts,
    output logic [63:0]      o_key
);
    import zka_pkg::*;

    // Largest ordinal plus offset stays below 57*B + 258
    localparam int ORD_W = $clog2(57 * BOARD_SQUARES + 258);

    logic [ROW_W-1:0] w_row;
    logic [ORD_W-1:0] w_col;
    logic [ORD_W-1:0] w_ord;
    logic [63:0]      w_const;
    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [63:0]      w_prod;
    logic [63:0]      w_xs;
    logic [63:0]      w_word;

    logic [63:0] r_z;
    logic [63:0] r_p;
    logic [63:0] r_acc;
    logic [63:0] r_key;
    logic        r_skip;
    logic        r_last;

    // Row and column of the item in the generation order
    always_comb begin
        case (i_mode)
            MODE_PIECE: begin
                w_row = ROW_W'(i_color) * ROW_W'(PIECE_KINDS) + ROW_W'(i_piece);
                w_col = ORD_W'(i_square);
            end
            MODE_EP: begin
                w_row = ROW_W'(EP_ROW_BASE) + ROW_W'(i_color);
                w_col = ORD_W'(i_square);
            end
            MODE_TURN: begin
                w_row = ROW_W'(TURN_ROW);
                w_col = ORD_W'(i_color);
            end
            default: begin
                w_row = '0;
                w_col = '0;
            end
        endcase
    end

    assign w_ord = ORD_W'(w_row) * ORD_W'(BOARD_SQUARES) + w_col + ORD_W'(ORD_OFFSET);

    always_comb begin
        case (i_cmd.csel)
            MC_GAMMA: w_const = GOLDEN_GAMMA;
            MC_A:     w_const = MIX_MUL_A;
            MC_B:     w_const = MIX_MUL_B;
            default:  w_const = GOLDEN_GAMMA;
        endcase
    end

    always_comb begin
        case (i_cmd.phase)
            PH_LL: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[31:0];
            end
            PH_HL: begin
                w_mul_a = r_z[63:32];
                w_mul_b = w_const[31:0];
            end
            PH_LH: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[63:32];
            end
            default: begin
                w_mul_a = r_z[31:0];
                w_mul_b = w_const[31:0];
            end
        endcase
    end

    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    always_comb begin
        case (i_cmd.xsel)
            XS_A:    w_xs = r_z ^ (r_z >> SHIFT_A);
            XS_B:    w_xs = r_z ^ (r_z >> SHIFT_B);
            default: w_xs = r_z;
        endcase
    end

    assign w_word = r_z ^ (r_z >> SHIFT_OUT);

    // Working word and partial product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z    <= 64'(w_ord);
            r_skip <= (i_mode == MODE_NONE);
            r_last <= i_last;
        end else if (i_cmd.mul_en) begin
            case (i_cmd.phase)
                PH_LL:   r_p <= w_prod;
                PH_HL:   r_p[63:32] <= r_p[63:32] + w_prod[31:0];
                PH_LH:   r_z <= {r_p[63:32] + w_prod[31:0], r_p[31:0]};
                default: r_p <= r_p;
            endcase
        end else if (i_cmd.xs_en) begin
            r_z <= w_xs;
        end
    end

    // Key accumulator; clear on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.fold && !r_skip) begin
            r_acc <= r_acc ^ w_word;
        end else if (i_cmd.emit) begin
            r_acc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_key <= r_acc;
        end
    end

    assign o_sts.last = r_last;
    assign o_key      = r_key;

endmodule

// ----- src/zka_ctrl.sv -----
// Controller of the Zobrist key accumulator: sequences load, multiply, xor-shift, fold, emit.
// Depends on zka_pkg; commands zka_datapath.
module zka_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  zka_pkg::t_dp_sts i_sts,
    output zka_pkg::t_dp_cmd o_cmd
);
    import zka_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_XS   = 5'b00100,
        S_FOLD = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    t_mphase r_phase, n_phase;
    t_mconst r_csel,  n_csel;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_csel      = r_csel;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.phase = r_phase;
        o_cmd.csel  = r_csel;
        o_cmd.xsel  = (r_csel == MC_GAMMA) ? XS_A : XS_B;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = PH_LL;
                    n_csel     = MC_GAMMA;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                case (r_phase)
                    PH_LL:   n_phase = PH_HL;
                    PH_HL:   n_phase = PH_LH;
                    default: begin
                        n_phase = PH_LL;
                        n_state = (r_csel == MC_B) ? S_FOLD : S_XS;
                    end
                endcase
            end
            S_XS: begin
                o_cmd.xs_en = 1'b1;
                n_csel      = (r_csel == MC_GAMMA) ? MC_A : MC_B;
                n_state     = S_MUL;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LL;
            r_csel      <= MC_GAMMA;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_csel      <= n_csel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for zobrist_key_accumulator: a queue-fed request driver, a key monitor
// and an independent splitmix64 key predictor. Depends on zka_pkg and the RTL under src.
`timescale 1ns / 1ps

module testbench;
    import zka_pkg::*;

    localparam int          BOARD_SQUARES = 256;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 40;     // settling time after the last key
    localparam int          TARGET_ITEMS  = 1050;
    localparam int          HOLD_AFTER    = 250;    // requests seen before the long key hold-off
    localparam int          HOLD_CYCLES   = 500;
    // splitmix64 constants, kept apart from the package on purpose
    localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL_B = 64'h94D0_49BB_1331_11EB;

    // One request with its sender-side pacing
    typedef struct {
        logic [1:0]  mode;
        logic [2:0]  color;
        logic [2:0]  piece;
        logic [7:0]  square;
        logic        last;
        int unsigned gap;      // idle cycles before the request is offered
        bit          drain;    // hold the request until every key has come out, except during the key hold-off
    } t_zobrist_req;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode   = MODE_PIECE;
    logic [2:0]  i_color  = '0;
    logic [2:0]  i_piece  = '0;
    logic [7:0]  i_square = '0;
    logic        i_last   = 1'b0;
    logic        o_valid;
    logic        i_stall  = 1'b0;
    logic [63:0] o_key;

    t_zobrist_req request_q[$];
    logic [63:0]  expected_keys[$];
    logic [63:0]  running_key = '0;     // predicted accumulator contents
    t_zobrist_req active_req;
    int unsigned  idle_cycles = 0;
    int unsigned  rx_wait     = 0;
    int unsigned  keys_seen   = 0;
    int unsigned  mismatches  = 0;
    int unsigned  cycle_cnt   = 0;
    int unsigned  queued_cnt  = 0;
    int unsigned  seen_reqs   = 0;
    int unsigned  hold_left   = 0;
    bit           hold_done   = 1'b0;
    logic         rx_hold     = 1'b0;
    bit           sender_calm = 1'b0;
    bit           drain_next  = 1'b0;

    zobrist_key_accumulator #(
        .BOARD_SQUARES(BOARD_SQUARES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_color (i_color),
        .i_piece (i_piece),
        .i_square(i_square),
        .i_last  (i_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_key   (o_key)
    );

    always #4 i_clk = ~i_clk;

    // splitmix64 finalizer of (ordinal + 2) * gamma, all modulo 2^64
    function automatic logic [63:0] splitmix_word(input logic [63:0] ordinal);
        logic [63:0] z;
        z = (ordinal + 64'd2) * SM_GAMMA;
        z = (z ^ (z >> 30)) * SM_MUL_A;
        z = (z ^ (z >> 27)) * SM_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Fold one accepted request into the predicted key; queue the key on last.
    task automatic fold_request(input t_zobrist_req req);
        logic [63:0] color_w;
        logic [63:0] board_w;
        color_w = 64'(req.color);
        board_w = 64'(BOARD_SQUARES);
        case (req.mode)
            MODE_PIECE: begin
                running_key ^= splitmix_word((color_w * 64'd7 + 64'(req.piece)) * board_w
                                             + 64'(req.square));
            end
            MODE_EP: begin
                running_key ^= splitmix_word(64'd35 * board_w + color_w * board_w
                                             + 64'(req.square));
            end
            MODE_TURN: begin
                running_key ^= splitmix_word(64'd40 * board_w + color_w);
            end
            default: ;  // unused code: no word, last still counts
        endcase
        if (req.last) begin
            expected_keys.push_back(running_key);
            running_key = '0;
        end
    endtask

    task automatic add_request(input logic [1:0] mode, input logic [2:0] color,
                               input logic [2:0] piece, input logic [7:0] square,
                               input logic last);
        t_zobrist_req req;
        req.mode   = mode;
        req.color  = color;
        req.piece  = piece;
        req.square = square;
        req.last   = last;
        req.gap    = sender_calm ? 0 : $urandom_range(0, 9);
        req.drain  = drain_next;
        drain_next = 1'b0;
        request_q.push_back(req);
        queued_cnt++;
    endtask

    // Mostly well-formed placements; a share of full-width noise and unused mode codes.
    task automatic add_random_request(input logic last);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            add_request(2'($urandom), 3'($urandom), 3'($urandom), 8'($urandom), last);
        end else if (sel < 72) begin
            add_request(MODE_PIECE, 3'($urandom_range(0, 4)), 3'($urandom_range(0, 6)),
                        8'($urandom_range(0, 255)), last);
        end else if (sel < 86) begin
            add_request(MODE_EP, 3'($urandom_range(0, 4)), 3'($urandom),
                        8'($urandom_range(0, 255)), last);
        end else begin
            add_request(MODE_TURN, 3'($urandom_range(0, 4)), 3'($urandom), 8'($urandom),
                        last);
        end
    endtask

    // Driver: fold the request accepted at this edge, then offer the next one.
    always @(posedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (i_valid && !o_stall) begin
                fold_request(active_req);
            end
            // hold the payload while the block stalls it; keep offering during the key hold-off
            if (!i_valid || !o_stall) begin
                if (request_q.size() != 0
                        && !(request_q[0].drain && expected_keys.size() != 0 && !rx_hold)) begin
                    if (idle_cycles < request_q[0].gap) begin
                        idle_cycles++;
                    end else begin
                        active_req  = request_q.pop_front();
                        idle_cycles = 0;
                        i_mode   <= active_req.mode;
                        i_color  <= active_req.color;
                        i_piece  <= active_req.piece;
                        i_square <= active_req.square;
                        i_last   <= active_req.last;
                        offer = 1'b1;
                    end
                end
                i_valid <= offer;
            end
        end
    end

    // Long hold-off on the key channel: count requests seen, then stall keys for a
    // long stretch so the output register fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                seen_reqs++;
            end
            if (!hold_done && seen_reqs >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
            end
            rx_hold <= (hold_left != 0);
        end
    end

    // Monitor: compare each accepted key with the oldest prediction, then draw a stall.
    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                keys_seen++;
                if (expected_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected key %h with no request pending", o_key);
                    end
                end else begin
                    want = expected_keys.pop_front();
                    if (o_key !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("key mismatch: expected %h, got %h", want, o_key);
                        end
                    end
                end
                // every fourth batch of sixteen keys runs with no random stalls
                rx_wait = ((keys_seen / 16) % 4 == 1) ? 0 : $urandom_range(0, 9);
            end
            i_stall <= rx_hold || (rx_wait != 0);
            if (rx_wait != 0) begin
                rx_wait--;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned pos_len;

        // Directed: smallest and largest ordinals of each kind, ignored fields,
        // the unused mode code, a cancelling pair and a position spread over many items.
        add_request(MODE_PIECE, 3'd0, 3'd0, 8'd0, 1'b1);
        add_request(MODE_PIECE, 3'd7, 3'd7, 8'd255, 1'b1);
        add_request(MODE_PIECE, 3'd4, 3'd6, 8'd255, 1'b0);
        add_request(MODE_EP, 3'd0, 3'd7, 8'd0, 1'b0);
        add_request(MODE_EP, 3'd7, 3'd0, 8'd255, 1'b0);
        add_request(MODE_TURN, 3'd0, 3'd0, 8'd0, 1'b1);
        add_request(MODE_TURN, 3'd7, 3'd7, 8'd255, 1'b1);
        add_request(MODE_TURN, 3'd1, 3'd5, 8'd170, 1'b1);
        add_request(MODE_TURN, 3'd1, 3'd2, 8'd85, 1'b1);
        add_request(MODE_NONE, 3'd7, 3'd7, 8'd255, 1'b1);
        add_request(MODE_PIECE, 3'd2, 3'd3, 8'd17, 1'b0);
        add_request(MODE_NONE, 3'd5, 3'd1, 8'd99, 1'b0);
        add_request(MODE_NONE, 3'd0, 3'd0, 8'd0, 1'b1);
        add_request(MODE_PIECE, 3'd1, 3'd2, 8'd10, 1'b0);
        add_request(MODE_PIECE, 3'd1, 3'd2, 8'd10, 1'b1);
        add_request(MODE_EP, 3'd5, 3'd0, 8'd128, 1'b0);
        add_request(MODE_PIECE, 3'd6, 3'd5, 8'd64, 1'b0);
        add_request(MODE_TURN, 3'd4, 3'd0, 8'd0, 1'b0);
        add_request(MODE_PIECE, 3'd0, 3'd6, 8'd63, 1'b0);
        add_request(MODE_EP, 3'd4, 3'd0, 8'd40, 1'b1);

        // Random positions; the first one waits for the directed keys to drain.
        drain_next = 1'b1;
        while (queued_cnt < TARGET_ITEMS) begin
            pos_len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
            sender_calm = ((queued_cnt / 128) % 4) == 2;
            if ($urandom_range(0, 29) == 0) begin
                drain_next = 1'b1;
            end
            for (int k = 0; k < pos_len; k++) begin
                add_random_request(k == pos_len - 1);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every key to come out, then settle.
        while (request_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_keys.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/zka_pkg.sv
src/zka_datapath.sv
src/zka_ctrl.sv
src/zobrist_key_accumulator.sv
test/testbench.sv
